// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the payload fragmenter.
// Each expects clk_i, and CPF_ASSERT also rst_ni, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define CPF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/cpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpf_pkg
// Shared types and constants of the CAN payload fragmenter.
// ---------------------------------------------------------------------------
package cpf_pkg;

  localparam int unsigned MAX_PAYLOAD = 512;

  typedef enum logic [2:0] {
    KIND_SHORT     = 3'd0,
    KIND_FILL      = 3'd1,
    KIND_LONG_FILL = 3'd2,
    KIND_PROCESS   = 3'd3,
    KIND_ERROR     = 3'd4
  } frame_kind_e;

  typedef struct packed {
    frame_kind_e      kind;
    logic [7:0]       dest;
    logic [3:0]       len;
    logic [7:0][7:0]  data;
    logic             last;
  } frame_t;

  // Up to two frames per payload byte; frame1 is used only with frame0.
  typedef struct packed {
    logic   push0;
    logic   push1;
    frame_t frame0;
    frame_t frame1;
  } frame_push_t;

endpackage
`default_nettype wire

// ===== design/cpf_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpf_cfg_if
// Write channel for the own node id register.
// ---------------------------------------------------------------------------
interface cpf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] own_node_id;

  modport source (output valid, output own_node_id, input ready);
  modport sink   (input valid, input own_node_id, output ready);
endinterface
`default_nettype wire

// ===== design/cpf_item_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpf_item_if
// Payload byte channel: one payload byte per word.
// ---------------------------------------------------------------------------
interface cpf_item_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [15:0] payload_length;
  logic [7:0]  target_node;

  modport source (output valid, output payload_byte, output payload_length,
                  output target_node, input ready);
  modport sink   (input valid, input payload_byte, input payload_length,
                  input target_node, output ready);
endinterface
`default_nettype wire

// ===== design/cpf_frame_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpf_frame_if
// CAN frame channel: one frame per word.
// ---------------------------------------------------------------------------
interface cpf_frame_if;
  logic       valid;
  logic       ready;
  logic [2:0] frame_kind;
  logic [7:0] dest_node;
  logic [3:0] frame_length;
  logic [7:0] data0;
  logic [7:0] data1;
  logic [7:0] data2;
  logic [7:0] data3;
  logic [7:0] data4;
  logic [7:0] data5;
  logic [7:0] data6;
  logic [7:0] data7;
  logic       last_of_run;

  modport source (output valid, output frame_kind, output dest_node,
                  output frame_length, output data0, output data1, output data2,
                  output data3, output data4, output data5, output data6,
                  output data7, output last_of_run, input ready);
  modport sink   (input valid, input frame_kind, input dest_node,
                  input frame_length, input data0, input data1, input data2,
                  input data3, input data4, input data5, input data6,
                  input data7, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== design/cpf_segmenter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpf_segmenter
// Input register, packet state and one-byte frame building step.
// ---------------------------------------------------------------------------
module cpf_segmenter #(
  parameter int unsigned MAX_PAYLOAD = cpf_pkg::MAX_PAYLOAD
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           own_node_id_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           payload_byte_i,
  input  logic [15:0]          payload_length_i,
  input  logic [7:0]           target_node_i,
  input  logic                 room_i,
  output cpf_pkg::frame_push_t push_o
);
  import cpf_pkg::*;

  localparam int unsigned CHUNK_DEPTH = 7;
  localparam int unsigned SHORT_MAX   = 6;
  localparam int unsigned FILL_CAP    = 7;
  localparam int unsigned LONG_CAP    = 6;
  localparam int unsigned INDEX_MAX   = 255;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  // Input register
  logic        stg_valid_q, stg_valid_d;
  logic [7:0]  stg_byte_q;
  logic [15:0] stg_len_q;
  logic [7:0]  stg_tgt_q;

  // Packet state
  logic [15:0] taken_q, taken_d;
  logic [15:0] expected_q, expected_d;
  logic [15:0] start_q, start_d;
  logic [2:0]  fill_q, fill_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  target_q, target_d;
  logic        discard_q, discard_d;
  logic [7:0]  chunk_q [CHUNK_DEPTH];

  logic        fire;
  logic        accept;
  logic        chunk_we;
  logic        first;
  logic        len_bad;
  logic [15:0] exp_eff;
  logic [7:0]  tgt_eff;
  logic [15:0] taken_inc;
  logic [2:0]  fill_next;
  logic        last;
  logic        is_short;
  logic        cap_short_idx;
  logic        chunk_full;
  logic [7:0]  view [CHUNK_DEPTH];

  assign fire       = stg_valid_q & room_i;
  assign in_ready_o = ~stg_valid_q | fire;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (accept) begin
      stg_valid_d = 1'b1;
    end else if (fire) begin
      stg_valid_d = 1'b0;
    end
  end

  assign first         = (taken_q == 16'd0);
  assign len_bad       = (stg_len_q == 16'd0) || (stg_len_q > 16'(MAX_PAYLOAD));
  assign exp_eff       = first ? stg_len_q : expected_q;
  assign tgt_eff       = first ? stg_tgt_q : target_q;
  assign taken_inc     = taken_q + 16'd1;
  assign fill_next     = fill_q + 3'd1;
  assign last          = (taken_inc >= exp_eff);
  assign is_short      = (exp_eff <= 16'(SHORT_MAX));
  assign cap_short_idx = (start_q <= 16'(INDEX_MAX));
  assign chunk_full    = cap_short_idx ? (fill_next == 3'(FILL_CAP))
                                       : (fill_next == 3'(LONG_CAP));

  // Chunk as it stands after this byte; bytes past the fill read as zero.
  always_comb begin
    for (int i = 0; i < CHUNK_DEPTH; i++) begin
      if (3'(i) == fill_q) begin
        view[i] = stg_byte_q;
      end else if (3'(i) < fill_next) begin
        view[i] = chunk_q[i];
      end else begin
        view[i] = 8'h00;
      end
    end
  end

  always_comb begin
    taken_d    = taken_q;
    expected_d = expected_q;
    start_d    = start_q;
    fill_d     = fill_q;
    crc_d      = crc_q;
    target_d   = target_q;
    discard_d  = discard_q;
    chunk_we   = 1'b0;
    push_o     = '0;
    if (fire) begin
      if (discard_q) begin
        // drop the rest of a packet with a bad length
        taken_d = taken_inc;
        if (taken_inc >= expected_q) begin
          taken_d    = 16'd0;
          expected_d = 16'd0;
          discard_d  = 1'b0;
        end
      end else if (first && len_bad) begin
        push_o.push0       = 1'b1;
        push_o.frame0.kind = KIND_ERROR;
        push_o.frame0.dest = stg_tgt_q;
        push_o.frame0.last = 1'b1;
        if (stg_len_q > 16'd1) begin
          discard_d  = 1'b1;
          taken_d    = 16'd1;
          expected_d = stg_len_q;
        end
      end else begin
        chunk_we   = 1'b1;
        crc_d      = crc16_byte(crc_q, stg_byte_q);
        fill_d     = fill_next;
        taken_d    = taken_inc;
        expected_d = exp_eff;
        target_d   = tgt_eff;
        if (is_short) begin
          if (last) begin
            push_o.push0          = 1'b1;
            push_o.frame0.kind    = KIND_SHORT;
            push_o.frame0.dest    = tgt_eff;
            push_o.frame0.len     = 4'd2 + 4'(fill_next);
            push_o.frame0.data[0] = own_node_id_i;
            for (int i = 0; i < SHORT_MAX; i++) begin
              push_o.frame0.data[2 + i] = view[i];
            end
            push_o.frame0.last    = 1'b1;
          end
        end else if (chunk_full || last) begin
          push_o.push0       = 1'b1;
          push_o.frame0.dest = tgt_eff;
          push_o.frame0.last = ~last;
          if (cap_short_idx) begin
            push_o.frame0.kind    = KIND_FILL;
            push_o.frame0.len     = 4'd1 + 4'(fill_next);
            push_o.frame0.data[0] = start_q[7:0];
            for (int i = 0; i < FILL_CAP; i++) begin
              push_o.frame0.data[1 + i] = view[i];
            end
          end else begin
            push_o.frame0.kind    = KIND_LONG_FILL;
            push_o.frame0.len     = 4'd2 + 4'(fill_next);
            push_o.frame0.data[0] = start_q[15:8];
            push_o.frame0.data[1] = start_q[7:0];
            for (int i = 0; i < LONG_CAP; i++) begin
              push_o.frame0.data[2 + i] = view[i];
            end
          end
          start_d = start_q + 16'(fill_next);
          fill_d  = 3'd0;
        end
        if (!is_short && last) begin
          // closing process frame: length and CRC over the whole payload
          push_o.push1          = 1'b1;
          push_o.frame1.kind    = KIND_PROCESS;
          push_o.frame1.dest    = tgt_eff;
          push_o.frame1.len     = 4'd6;
          push_o.frame1.data[0] = own_node_id_i;
          push_o.frame1.data[2] = exp_eff[15:8];
          push_o.frame1.data[3] = exp_eff[7:0];
          push_o.frame1.data[4] = crc_d[15:8];
          push_o.frame1.data[5] = crc_d[7:0];
          push_o.frame1.last    = 1'b1;
        end
        if (last) begin
          taken_d    = 16'd0;
          expected_d = 16'd0;
          start_d    = 16'd0;
          fill_d     = 3'd0;
          crc_d      = 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      taken_q     <= 16'd0;
      expected_q  <= 16'd0;
      start_q     <= 16'd0;
      fill_q      <= 3'd0;
      crc_q       <= 16'd0;
      target_q    <= 8'd0;
      discard_q   <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
      taken_q     <= taken_d;
      expected_q  <= expected_d;
      start_q     <= start_d;
      fill_q      <= fill_d;
      crc_q       <= crc_d;
      target_q    <= target_d;
      discard_q   <= discard_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_byte_q <= payload_byte_i;
      stg_len_q  <= payload_length_i;
      stg_tgt_q  <= target_node_i;
    end
    if (chunk_we) begin
      chunk_q[fill_q] <= stg_byte_q;
    end
  end

endmodule
`default_nettype wire

// ===== design/cpf_frame_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpf_frame_fifo
// Result register: four frames deep, takes up to two frames per cycle.
// ---------------------------------------------------------------------------
module cpf_frame_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cpf_pkg::frame_push_t push_i,
  input  logic                 pop_i,
  output logic                 room_o,
  output logic                 valid_o,
  output cpf_pkg::frame_t      frame_o
);
  import cpf_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  frame_t            mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]    count_q, count_d;
  logic [PTR_W:0]    push_cnt;

  assign push_cnt = (PTR_W + 1)'(push_i.push0) + (PTR_W + 1)'(push_i.push1);
  assign room_o   = (count_q <= (PTR_W + 1)'(DEPTH - 2));
  assign valid_o  = (count_q != '0);
  assign frame_o  = mem_q[rd_q];

  always_comb begin
    wr_d    = wr_q + PTR_W'(push_cnt);
    rd_d    = pop_i ? rd_q + PTR_W'(1) : rd_q;
    count_d = count_q + push_cnt - (PTR_W + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= push_i.frame0;
    end
    if (push_i.push1) begin
      mem_q[wr_q + PTR_W'(1)] <= push_i.frame1;
    end
  end

endmodule
`default_nettype wire

// ===== design/can_payload_fragmenter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// can_payload_fragmenter
// Cuts a command payload, one byte per word, into CAN frames of up to 8 bytes.
// ---------------------------------------------------------------------------
// Usage:
//   item_i  carries one payload byte per word; length and target node are
//           taken from the first byte of each packet.
//   frame_o carries one CAN frame per word (short, fill, long fill, process
//           or length error); last_of_run marks the final frame of a byte.
//   cfg_i   writes the own node id; it is always ready and may be written
//           only while no packet is in flight.
// Path: a taken byte waits in the byte register; its frames are built there
//   and written into the result buffer, whose head drives frame_o.
// Throughput: one byte per cycle unless stalled. The closing byte of a
//   multi-frame packet makes two frames; the four-frame result buffer absorbs
//   the extra one, so bytes keep flowing at one per cycle while frames drain.
// Stall: when the receiver holds off, frames stay in the buffer; once it has
//   fewer than two free slots the byte register holds and item_i.ready drops.
// Reset: all packet state, the node id and the buffer clear; the partial
//   chunk store is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module can_payload_fragmenter #(
  parameter int unsigned MAX_PAYLOAD = cpf_pkg::MAX_PAYLOAD
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cpf_cfg_if.sink      cfg_i,
  cpf_item_if.sink     item_i,
  cpf_frame_if.source  frame_o
);
  import cpf_pkg::*;

  logic [7:0]  own_node_id_q;
  frame_push_t push;
  logic        room;
  logic        head_valid;
  frame_t      head;

  // Config register; always take the write.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_node_id_q <= 8'd0;
    end else if (cfg_i.valid) begin
      own_node_id_q <= cfg_i.own_node_id;
    end
  end

  // Byte register plus one-step frame builder.
  cpf_segmenter #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_segmenter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .own_node_id_i    (own_node_id_q),
    .in_valid_i       (item_i.valid),
    .in_ready_o       (item_i.ready),
    .payload_byte_i   (item_i.payload_byte),
    .payload_length_i (item_i.payload_length),
    .target_node_i    (item_i.target_node),
    .room_i           (room),
    .push_o           (push)
  );

  // Result buffer: parts the byte side from a stalled receiver.
  cpf_frame_fifo u_frame_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (head_valid & frame_o.ready),
    .room_o  (room),
    .valid_o (head_valid),
    .frame_o (head)
  );

  // Drive the frame channel from the buffer head.
  assign frame_o.valid        = head_valid;
  assign frame_o.frame_kind   = head.kind;
  assign frame_o.dest_node    = head.dest;
  assign frame_o.frame_length = head.len;
  assign frame_o.data0        = head.data[0];
  assign frame_o.data1        = head.data[1];
  assign frame_o.data2        = head.data[2];
  assign frame_o.data3        = head.data[3];
  assign frame_o.data4        = head.data[4];
  assign frame_o.data5        = head.data[5];
  assign frame_o.data6        = head.data[6];
  assign frame_o.data7        = head.data[7];
  assign frame_o.last_of_run  = head.last;

endmodule
`default_nettype wire

// ===== design/cpf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// cpf_checker
// Port-level checks of the payload fragmenter, bound to the top level.
// ---------------------------------------------------------------------------
module cpf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] frame_kind_i,
  input logic [3:0] frame_length_i,
  input logic [7:0] data0_i,
  input logic       last_of_run_i
);
  import cpf_pkg::*;

  // no frame while in reset
  `CPF_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> !out_valid_i, "frame valid in reset")

  // a frame rises only after the byte that caused it has passed the byte register and the result buffer
  `CPF_ASSERT(a_rise_latency, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2), "frame without byte two cycles back")

  // a chunk frame that is not last is followed at once by the process frame
  `CPF_ASSERT(a_process_follows, (out_valid_i && out_ready_i && !last_of_run_i && (frame_kind_i == KIND_FILL || frame_kind_i == KIND_LONG_FILL)) |=> (out_valid_i && frame_kind_i == KIND_PROCESS), "process frame missing")

  // a stalled frame holds
  `CPF_ASSERT(a_stall_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(frame_kind_i) && $stable(frame_length_i) && $stable(data0_i)), "stalled frame changed")

endmodule

bind can_payload_fragmenter cpf_checker u_cpf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (item_i.valid),
  .in_ready_i     (item_i.ready),
  .out_valid_i    (frame_o.valid),
  .out_ready_i    (frame_o.ready),
  .frame_kind_i   (frame_o.frame_kind),
  .frame_length_i (frame_o.frame_length),
  .data0_i        (frame_o.data0),
  .last_of_run_i  (frame_o.last_of_run)
);
`default_nettype wire
